// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the heap queue RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising clock edge outside reset.
`define HMQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("heap queue check failed");

// Condition must never be seen outside reset.
`define HMQ_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `HMQ_ASSERT(lbl, clk, rstn, !(cond))

`endif

// ===== hw/rtl/hmq_pkg.sv =====
// Package for the binary min-heap queue: field widths, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps

package hmq_pkg;

  localparam int unsigned KEY_W        = 20;
  localparam int unsigned OCC_W        = 10;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned DEF_CAPACITY = 1023;
  localparam int unsigned DEF_KEY_BITS = 20;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } hmq_status_e;

  // Command as classified by the front end
  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_EXTRACT,
    CMD_ERR_EMPTY,
    CMD_ERR_FULL
  } hmq_kind_e;

endpackage

// ===== hw/rtl/hmq_if.sv =====
// Valid/ready channel interfaces for the heap queue: operation in, result out.
// Depends on hmq_pkg.
`timescale 1ns / 1ps

interface hmq_in_if import hmq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [KEY_W-1:0] key;

  modport source (output valid, opcode, key, input ready);
  modport sink   (input valid, opcode, key, output ready);
endinterface

interface hmq_out_if import hmq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    min_key;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, min_key, status, occupancy, input ready);
  modport sink   (input valid, min_key, status, occupancy, output ready);
endinterface

// ===== hw/rtl/binary_min_heap_queue.sv =====
// Binary min-heap priority queue with valid/ready channels.
// in_ch carries an operation: opcode insert or extract-minimum, plus a key.
// out_ch returns one result per operation: removed minimum (zero unless a
// successful extract), status (ok, extract from empty, insert into full)
// and the number of keys held afterwards.
// The moving key travels at most floor(log2 CAPACITY) levels, 9 at the
// default. At each level the heap engine reads and then writes its single
// store, and it starts on the next operation only once the last one has
// gone to the output register.
// A two-entry command queue sits between front end and engine; input is
// taken while it has room, including while a result waits in the output
// register. A stalled receiver holds the result steady; the engine waits
// with its next result until the register drains.
// Reset empties the queue; the heap store needs no clearing pass since only
// written slots are ever read.
// Depends on hmq_pkg, hmq_if, hmq_front, hmq_cmd_fifo, hmq_engine.
`timescale 1ns / 1ps

module binary_min_heap_queue import hmq_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hmq_in_if.sink    in_ch,
  hmq_out_if.source out_ch
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMD_W = $bits(hmq_kind_e) + KEY_BITS + CW;

  logic             push, fifo_full, pop, fifo_valid;
  logic [CMD_W-1:0] front_cmd, back_cmd;

  hmq_front #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cmd_valid_o (push),
    .cmd_o       (front_cmd),
    .cmd_ready_i (!fifo_full)
  );

  hmq_cmd_fifo #(
    .WIDTH (CMD_W)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (back_cmd)
  );

  hmq_engine #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (pop),
    .out_ch      (out_ch)
  );

endmodule

// ===== hw/rtl/hmq_front.sv =====
// Front end: accepts operations, tracks the projected key count and
// classifies each operation into a command. Depends on hmq_pkg, hmq_if.
`timescale 1ns / 1ps

module hmq_front import hmq_pkg::*; #(
  parameter  int unsigned CAPACITY = DEF_CAPACITY,
  parameter  int unsigned KEY_BITS = DEF_KEY_BITS,
  localparam int unsigned CW       = $clog2(CAPACITY + 1),
  localparam int unsigned CMD_W    = $bits(hmq_kind_e) + KEY_BITS + CW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  hmq_in_if.sink           in_ch,
  output logic             cmd_valid_o,
  output logic [CMD_W-1:0] cmd_o,
  input  logic             cmd_ready_i
);

  typedef struct packed {
    hmq_kind_e             kind;
    logic [KEY_BITS-1:0]   key;
    logic [CW-1:0]         count;
  } cmd_t;

  logic [CW-1:0]             count_q, count_d;
  logic                      transfer;
  logic [KEY_BITS+KEY_W-1:0] key_wide;
  cmd_t                      cmd;

  assign in_ch.ready = cmd_ready_i;
  assign transfer    = in_ch.valid && cmd_ready_i;
  assign key_wide    = {{KEY_BITS{1'b0}}, in_ch.key};

  always_comb begin
    count_d   = count_q;
    cmd.key   = key_wide[KEY_BITS-1:0];
    cmd.count = count_q;
    if (in_ch.opcode == OP_INSERT) begin
      if (count_q >= CW'(CAPACITY)) begin
        cmd.kind = CMD_ERR_FULL;
      end else begin
        cmd.kind = CMD_INSERT;
        count_d  = count_q + CW'(1);
      end
    end else begin
      if (count_q == '0) begin
        cmd.kind = CMD_ERR_EMPTY;
      end else begin
        cmd.kind = CMD_EXTRACT;
        count_d  = count_q - CW'(1);
      end
    end
    // command carries the count after the operation
    cmd.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (transfer) begin
      count_q <= count_d;
    end
  end

  assign cmd_valid_o = in_ch.valid;
  assign cmd_o       = cmd;

endmodule

// ===== hw/rtl/hmq_cmd_fifo.sv =====
// Two-entry command queue between the front end and the heap engine.
// No package dependencies.
`timescale 1ns / 1ps

module hmq_cmd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;
  logic             do_push, do_pop;

  assign full_o  = fill_q[1];
  assign valid_o = (fill_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/hmq_engine.sv =====
// Back end: heap store, sift-up / sift-down sequencer and result register.
// Depends on hmq_pkg, hmq_if, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hmq_engine import hmq_pkg::*; #(
  parameter  int unsigned CAPACITY = DEF_CAPACITY,
  parameter  int unsigned KEY_BITS = DEF_KEY_BITS,
  localparam int unsigned CW       = $clog2(CAPACITY + 1),
  localparam int unsigned CMD_W    = $bits(hmq_kind_e) + KEY_BITS + CW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  logic [CMD_W-1:0] cmd_i,
  output logic             cmd_pop_o,
  hmq_out_if.source        out_ch
);

  typedef struct packed {
    hmq_kind_e             kind;
    logic [KEY_BITS-1:0]   key;
    logic [CW-1:0]         count;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EX_RD,
    S_EX_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_EMIT
  } state_e;

  cmd_t cmd;
  assign cmd = cmd_i;

  // heap store, slot 0 unused
  logic [KEY_BITS-1:0] heap_mem [CAPACITY+1];
  logic [KEY_BITS-1:0] rd_a_q, rd_b_q;
  logic [CW-1:0]       rd_addr_a, rd_addr_b, mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;
  logic                mem_we;

  state_e              state_q, state_d;
  hmq_kind_e           kind_q, kind_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic [KEY_BITS-1:0] val_q, val_d;
  logic [KEY_BITS-1:0] min_q, min_d;

  logic                out_valid_q, out_valid_d;
  logic [KEY_W-1:0]    out_min_q, out_min_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [OCC_W-1:0]    out_occ_q, out_occ_d;

  logic [CW:0]               child_l, child_r;
  logic                      has_l, has_r, l_lt_r;
  logic [KEY_BITS+KEY_W-1:0] min_wide;
  logic [CW+OCC_W-1:0]       occ_wide;

  assign child_l  = {pos_q, 1'b0};
  assign child_r  = {pos_q, 1'b1};
  assign has_l    = child_l <= {1'b0, cnt_q};
  assign has_r    = child_r <= {1'b0, cnt_q};
  assign l_lt_r   = !has_r || (rd_a_q < rd_b_q);
  assign min_wide = {{KEY_W{1'b0}}, min_q};
  assign occ_wide = {{OCC_W{1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= heap_mem[rd_addr_a];
    rd_b_q <= heap_mem[rd_addr_b];
  end

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    val_d        = val_q;
    min_d        = min_q;
    out_valid_d  = out_valid_q;
    out_min_d    = out_min_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    cmd_pop_o    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = pos_q;
    mem_wdata    = val_q;
    rd_addr_a    = '0;
    rd_addr_b    = '0;

    if (out_valid_q && out_ch.ready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          kind_d    = cmd.kind;
          cnt_d     = cmd.count;
          val_d     = cmd.key;
          min_d     = '0;
          pos_d     = cmd.count;
          unique case (cmd.kind)
            CMD_INSERT:  state_d = S_UP_RD;
            CMD_EXTRACT: begin
              pos_d   = cmd.count + CW'(1);   // slot of the last entry
              state_d = S_EX_RD;
            end
            default:     state_d = S_EMIT;
          endcase
        end
      end
      S_EX_RD: begin
        rd_addr_a = CW'(1);
        rd_addr_b = pos_q;
        state_d   = S_EX_LD;
      end
      S_EX_LD: begin
        min_d   = rd_a_q;
        val_d   = rd_b_q;
        pos_d   = CW'(1);
        state_d = (cnt_q == '0) ? S_EMIT : S_DN_RD;
      end
      S_UP_RD: begin
        if (pos_q == CW'(1)) begin
          mem_we  = 1'b1;
          state_d = S_EMIT;
        end else begin
          rd_addr_a = pos_q >> 1;
          state_d   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (val_q < rd_a_q) begin
          // parent moves down into the hole
          mem_wdata = rd_a_q;
          pos_d     = pos_q >> 1;
          state_d   = S_UP_RD;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DN_RD: begin
        if (!has_l) begin
          mem_we  = 1'b1;
          state_d = S_EMIT;
        end else begin
          rd_addr_a = child_l[CW-1:0];
          rd_addr_b = has_r ? child_r[CW-1:0] : child_l[CW-1:0];
          state_d   = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (l_lt_r && (rd_a_q < val_q)) begin
          mem_wdata = rd_a_q;
          pos_d     = child_l[CW-1:0];
          state_d   = S_DN_RD;
        end else if (has_r && (rd_b_q < val_q)) begin
          // equal children land here: right one wins
          mem_wdata = rd_b_q;
          pos_d     = child_r[CW-1:0];
          state_d   = S_DN_RD;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          out_min_d   = min_wide[KEY_W-1:0];
          out_occ_d   = occ_wide[OCC_W-1:0];
          unique case (kind_q)
            CMD_ERR_EMPTY: out_status_d = ST_EMPTY;
            CMD_ERR_FULL:  out_status_d = ST_FULL;
            default:       out_status_d = ST_OK;
          endcase
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    cnt_q        <= cnt_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    min_q        <= min_d;
    out_min_q    <= out_min_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.min_key   = out_min_q;
  assign out_ch.status    = out_status_q;
  assign out_ch.occupancy = out_occ_q;

  `HMQ_ASSERT(a_err_min_zero, clk_i, rst_ni,
              (out_valid_q && out_status_q != ST_OK) |-> (out_min_q == '0))
  `HMQ_ASSERT(a_pos_in_heap, clk_i, rst_ni,
              (state_q == S_UP_RD || state_q == S_UP_CMP || state_q == S_DN_RD ||
               state_q == S_DN_CMP) |-> (pos_q != '0 && pos_q <= cnt_q))
  `HMQ_ASSERT(a_emit_loads, clk_i, rst_ni,
              (state_q == S_EMIT && (!out_valid_q || out_ch.ready)) |=> out_valid_q)
  `HMQ_ASSERT_NEVER(a_write_when_idle, clk_i, rst_ni,
                    mem_we && (state_q == S_IDLE || state_q == S_EMIT))

endmodule
